// ===== rtl/assert_macros.svh =====
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in this cycle implies consequent in the next one, off during reset.
`define BML_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("bump map lighting: next-cycle check failed");

// Antecedent implies consequent in the same cycle, off during reset.
`define BML_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("bump map lighting: same-cycle check failed");

// A reset cycle implies consequent in the next one.
`define BML_ASSERT_RESET(lbl, clk, rst_n, cons) \
  lbl: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
    else $error("bump map lighting: post-reset check failed");

`endif

// ===== rtl/bml_pkg.sv =====
// Types, constants and helpers shared by the bump map lighting modules.
package bml_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int QDEPTH = 4;
  localparam int QCNT_W = 3;

  localparam int WC_W = 14;
  localparam int HC_W = 17;
  localparam int DX_W = 14;
  localparam int DY_W = 17;
  localparam int MIN_DIM = 3;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LIGHT_X      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_LIGHT_Y      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_BASE_DEPTH   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_BEAT_DEPTH   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_BEAT_FRAMES  = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_OPTIONS      = 3'd7;

  localparam int OPT_INVERT = 0;
  localparam int OPT_DOT    = 1;
  localparam int OPT_BEAT   = 2;

  localparam logic [1:0] BLEND_ADD  = 2'd1;
  localparam logic [1:0] BLEND_MEAN = 2'd2;

  localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic [9:0]  LIGHT_X_RST      = 10'd320;
  localparam logic [11:0] LIGHT_Y_RST      = 12'd240;
  localparam logic [6:0]  BASE_DEPTH_RST   = 7'd30;
  localparam logic [6:0]  BEAT_DEPTH_RST   = 7'd100;
  localparam logic [6:0]  BEAT_FRAMES_RST  = 7'd15;
  localparam logic [4:0]  OPTIONS_RST      = 5'd0;

  localparam logic [6:0]  DEPTH_MAX   = 7'd127;
  localparam logic [7:0]  CH_CLAMP    = 8'd254;
  localparam logic [7:0]  CH_MAX      = 8'd255;
  localparam int          SLOPE_MAX   = 127;
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          SCALE_SHIFT = 11;
  localparam int          LIGHT_SHIFT = 8 + 6;
  localparam logic [23:0] WHITE       = 24'hFFFFFF;

  typedef struct packed {
    logic [10:0] frame_width;
    logic [12:0] frame_height;
    logic [9:0]  light_x;
    logic [11:0] light_y;
    logic [6:0]  base_depth;
    logic [6:0]  beat_depth;
    logic [6:0]  beat_frames;
    logic [4:0]  options;
  } bml_cfg_t;

  typedef struct packed {
    logic [23:0]            center;
    logic [7:0]             h_l;
    logic [7:0]             h_r;
    logic [7:0]             h_u;
    logic [7:0]             h_d;
    logic signed [DX_W-1:0] dx;
    logic signed [DY_W-1:0] dy;
    logic [6:0]             depth;
    logic                   flat;
    logic                   dark1;
    logic                   two;
    logic                   dark2;
    logic                   last2;
  } bml_item_t;

  function automatic logic [7:0] max_channel(input logic [23:0] c);
    logic [7:0] m;
    m = (c[7:0] > c[15:8]) ? c[7:0] : c[15:8];
    return (m > c[23:16]) ? m : c[23:16];
  endfunction

endpackage

// ===== rtl/bump_map_lighting.sv =====
// Top level of the bump map point-light shader.
// Takes RGB pixels in raster order and returns the lit frame one row behind: no
// result during the first input row, one result per pixel after that, and two per
// pixel on the last row (the last output row is the dark border). Steady rows take
// one pixel per clock while the output is not stalled; on the last row the single
// output port limits intake. After reset and after each register write, input is
// held while the serial divider computes the depth decay step. Frame size, light
// position, depth and options are written through the cfg port; the user must
// write them only while idle, as the block itself does not enforce this.
module bump_map_lighting #(
  parameter int MAX_WIDTH  = bml_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bml_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [23:0]                    in_tdata,   // [23:0] pixel_color
  input  logic                           in_tuser,   // [0] is_beat
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [23:0]                    out_tdata,  // [23:0] out_color
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bml_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [bml_pkg::CFG_DATA_W-1:0] cfg_data
);

  bml_pkg::bml_cfg_t  cfg_r;
  bml_pkg::bml_item_t push_item, head;
  logic               cfg_wr, push, pop, q_valid, div_busy;
  logic [6:0]         decay_step;
  logic [bml_pkg::QCNT_W-1:0] q_count;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= bml_pkg::FRAME_WIDTH_RST;
      cfg_r.frame_height <= bml_pkg::FRAME_HEIGHT_RST;
      cfg_r.light_x      <= bml_pkg::LIGHT_X_RST;
      cfg_r.light_y      <= bml_pkg::LIGHT_Y_RST;
      cfg_r.base_depth   <= bml_pkg::BASE_DEPTH_RST;
      cfg_r.beat_depth   <= bml_pkg::BEAT_DEPTH_RST;
      cfg_r.beat_frames  <= bml_pkg::BEAT_FRAMES_RST;
      cfg_r.options      <= bml_pkg::OPTIONS_RST;
    end else if (cfg_wr) begin
      case (cfg_addr)
        bml_pkg::REG_FRAME_WIDTH:  cfg_r.frame_width  <= cfg_data[10:0];
        bml_pkg::REG_FRAME_HEIGHT: cfg_r.frame_height <= cfg_data[12:0];
        bml_pkg::REG_LIGHT_X:      cfg_r.light_x      <= cfg_data[9:0];
        bml_pkg::REG_LIGHT_Y:      cfg_r.light_y      <= cfg_data[11:0];
        bml_pkg::REG_BASE_DEPTH:   cfg_r.base_depth   <= cfg_data[6:0];
        bml_pkg::REG_BEAT_DEPTH:   cfg_r.beat_depth   <= cfg_data[6:0];
        bml_pkg::REG_BEAT_FRAMES:  cfg_r.beat_frames  <= cfg_data[6:0];
        bml_pkg::REG_OPTIONS:      cfg_r.options      <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  bml_decay_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (cfg_wr),
    .cfg     (cfg_r),
    .step    (decay_step),
    .busy    (div_busy)
  );

  bml_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .decay_step (decay_step),
    .div_busy   (div_busy),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .q_count    (q_count),
    .push       (push),
    .push_item  (push_item)
  );

  bml_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .not_empty (q_valid),
    .head      (head),
    .count     (q_count)
  );

  bml_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_item     (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/bml_decay_div.sv =====
// Serial divider producing the per-frame depth decay step.
module bml_decay_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              restart,
  input  bml_pkg::bml_cfg_t cfg,
  output logic [6:0]        step,
  output logic              busy
);

  logic       pend_r;
  logic       act_r;
  logic [2:0] cnt_r;
  logic [6:0] rem_r;
  logic [6:0] quo_r;
  logic [6:0] dur;
  logic [6:0] diff;
  logic [7:0] trial;
  logic       ge;

  always_comb begin
    dur   = (cfg.beat_frames == '0) ? 7'd1 : cfg.beat_frames;
    diff  = (cfg.base_depth > cfg.beat_depth) ? cfg.base_depth - cfg.beat_depth
                                              : cfg.beat_depth - cfg.base_depth;
    trial = {rem_r, quo_r[6]};
    ge    = trial >= {1'b0, dur};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b1;
      act_r  <= 1'b0;
      cnt_r  <= '0;
    end else if (restart) begin
      pend_r <= 1'b1;
      act_r  <= 1'b0;
    end else if (pend_r) begin
      pend_r <= 1'b0;
      act_r  <= 1'b1;
      cnt_r  <= 3'd7;
      rem_r  <= '0;
      quo_r  <= diff;
    end else if (act_r) begin
      rem_r <= ge ? 7'(trial - {1'b0, dur}) : trial[6:0];
      quo_r <= {quo_r[5:0], ge};
      cnt_r <= cnt_r - 3'd1;
      if (cnt_r == 3'd1) begin
        act_r <= 1'b0;
      end
    end
  end

  assign step = quo_r;
  assign busy = pend_r | act_r;

endmodule

// ===== rtl/bml_front.sv =====
// Front end: raster counters, frame depth control, row stores and neighbour gather.
module bml_front #(
  parameter int MAX_WIDTH  = bml_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bml_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bml_pkg::bml_cfg_t           cfg,
  input  logic [6:0]                  decay_step,
  input  logic                        div_busy,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [23:0]                 in_tdata,
  input  logic                        in_tuser,
  input  logic [bml_pkg::QCNT_W-1:0]  q_count,
  output logic                        push,
  output bml_pkg::bml_item_t          push_item
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);

  logic [23:0] color_mem [MAX_WIDTH];
  logic [7:0]  height_mem [MAX_WIDTH];

  logic [XW-1:0] col_r, col_nxt;
  logic [YW-1:0] row_r, row_nxt;
  logic [6:0]    depth_r, depth_nxt;
  logic [6:0]    bfl_r, bfl_nxt;
  logic [23:0]   left_r;

  logic [bml_pkg::WC_W-1:0] wc;
  logic [bml_pkg::HC_W-1:0] hc;
  logic [XW-1:0] wm1, cx, x;
  logic [YW-1:0] hm1, cy, y, ym1;
  logic          last_col, last_row, acc;
  logic [6:0]    depth_mid, bfl_mid;
  logic [7:0]    depth_sum;

  logic          b_valid_r, b_has_r, b_last_col_r, b_two_r;
  logic          b_border_r, b_dark1_r, b_dark2_r;
  logic [XW-1:0] b_x_r;
  logic [23:0]   b_pix_r;
  logic [6:0]    b_depth_r;
  logic signed [bml_pkg::DX_W-1:0] b_dx_r;
  logic signed [bml_pkg::DY_W-1:0] b_dy_r;
  logic [23:0]   rd_c_r, rd_r_r;
  logic [7:0]    rd_h_r;
  logic [7:0]    hl, hr, hu, hd;

  always_comb begin
    wc = bml_pkg::WC_W'(cfg.frame_width);
    if (wc < bml_pkg::WC_W'(bml_pkg::MIN_DIM)) wc = bml_pkg::WC_W'(bml_pkg::MIN_DIM);
    if (wc > bml_pkg::WC_W'(MAX_WIDTH)) wc = bml_pkg::WC_W'(MAX_WIDTH);
    hc = bml_pkg::HC_W'(cfg.frame_height);
    if (hc < bml_pkg::HC_W'(bml_pkg::MIN_DIM)) hc = bml_pkg::HC_W'(bml_pkg::MIN_DIM);
    if (hc > bml_pkg::HC_W'(MAX_HEIGHT)) hc = bml_pkg::HC_W'(MAX_HEIGHT);
    wm1 = XW'(wc - bml_pkg::WC_W'(1));
    hm1 = YW'(hc - bml_pkg::HC_W'(1));
    cx  = (bml_pkg::WC_W'(cfg.light_x) < bml_pkg::WC_W'(wm1)) ? XW'(cfg.light_x) : wm1;
    cy  = (bml_pkg::HC_W'(cfg.light_y) < bml_pkg::HC_W'(hm1)) ? YW'(cfg.light_y) : hm1;
    x   = (col_r >= wm1) ? wm1 : col_r;
    y   = (row_r >= hm1) ? hm1 : row_r;
    ym1 = y - YW'(1);
    last_col = (x == wm1);
    last_row = (y == hm1);
  end

  assign in_tready = !div_busy &&
    (bml_pkg::QCNT_W'(q_count + bml_pkg::QCNT_W'(b_valid_r)) <
     bml_pkg::QCNT_W'(bml_pkg::QDEPTH));
  assign acc = in_tvalid && in_tready;

  always_comb begin
    depth_mid = depth_r;
    bfl_mid   = bfl_r;
    if (x == '0 && y == '0) begin
      if (cfg.options[bml_pkg::OPT_BEAT] && in_tuser) begin
        depth_mid = cfg.beat_depth;
        bfl_mid   = cfg.beat_frames;
      end else if (bfl_r == '0) begin
        depth_mid = cfg.base_depth;
      end
    end
    depth_nxt = depth_mid;
    bfl_nxt   = bfl_mid;
    depth_sum = {1'b0, depth_mid} + {1'b0, decay_step};
    if (last_col && last_row && bfl_mid != '0) begin
      bfl_nxt = bfl_mid - 7'd1;
      if (bfl_nxt != '0) begin
        if (cfg.beat_depth > cfg.base_depth) begin
          depth_nxt = (decay_step > depth_mid) ? 7'd0 : depth_mid - decay_step;
        end else begin
          depth_nxt = (depth_sum > {1'b0, bml_pkg::DEPTH_MAX}) ? bml_pkg::DEPTH_MAX
                                                                : depth_sum[6:0];
        end
      end
    end
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : y + YW'(1);
    end else begin
      col_nxt = x + XW'(1);
      row_nxt = y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      depth_r <= bml_pkg::BASE_DEPTH_RST;
      bfl_r   <= '0;
    end else if (acc) begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      depth_r <= depth_nxt;
      bfl_r   <= bfl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_c_r       <= color_mem[x];
      rd_r_r       <= color_mem[x + XW'(1)];
      color_mem[x] <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_h_r <= height_mem[x];
    end
    if (b_valid_r && b_has_r) begin
      height_mem[b_x_r] <= bml_pkg::max_channel(rd_c_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= acc;
    end
    if (acc) begin
      b_has_r      <= (y != '0);
      b_x_r        <= x;
      b_pix_r      <= in_tdata;
      b_depth_r    <= depth_mid;
      b_last_col_r <= last_col;
      b_two_r      <= last_row;
      b_border_r   <= (x == '0) || (y == YW'(1)) || last_col;
      b_dark1_r    <= cfg.options[bml_pkg::OPT_DOT] && (x == cx) && (ym1 == cy);
      b_dark2_r    <= cfg.options[bml_pkg::OPT_DOT] && (x == cx) && (y == cy);
      b_dx_r       <= $signed(bml_pkg::DX_W'(x)) - $signed(bml_pkg::DX_W'(cx));
      b_dy_r       <= $signed(bml_pkg::DY_W'(ym1)) - $signed(bml_pkg::DY_W'(cy));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (b_valid_r) begin
      if (b_last_col_r) begin
        left_r <= '0;
      end else if (b_has_r) begin
        left_r <= rd_c_r;
      end
    end
  end

  always_comb begin
    hl = bml_pkg::max_channel(left_r);
    hr = bml_pkg::max_channel(rd_r_r);
    hu = rd_h_r;
    hd = bml_pkg::max_channel(b_pix_r);
    push = b_valid_r && b_has_r;
    push_item.center = rd_c_r;
    push_item.h_l    = hl;
    push_item.h_r    = hr;
    push_item.h_u    = hu;
    push_item.h_d    = hd;
    push_item.dx     = b_dx_r;
    push_item.dy     = b_dy_r;
    push_item.depth  = b_depth_r;
    push_item.flat   = b_border_r || (hl == '0 && hr == '0 && hu == '0 && hd == '0);
    push_item.dark1  = b_dark1_r;
    push_item.two    = b_two_r;
    push_item.dark2  = b_dark2_r;
    push_item.last2  = b_last_col_r;
  end

endmodule

// ===== rtl/bml_queue.sv =====
// Short FIFO between the front end and the shading back end.
module bml_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  bml_pkg::bml_item_t         push_item,
  input  logic                       pop,
  output logic                       not_empty,
  output bml_pkg::bml_item_t         head,
  output logic [bml_pkg::QCNT_W-1:0] count
);

  localparam int PW = $clog2(bml_pkg::QDEPTH);

  bml_pkg::bml_item_t slots [bml_pkg::QDEPTH];
  logic [PW-1:0]      wptr_r, rptr_r;
  logic [bml_pkg::QCNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + PW'(1);
      if (pop)  rptr_r <= rptr_r + PW'(1);
      count_r <= count_r + bml_pkg::QCNT_W'(push) - bml_pkg::QCNT_W'(pop);
    end
  end

  assign head      = slots[rptr_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

endmodule

// ===== rtl/bml_back.sv =====
// Back end: slope terms, brightness, clamp, blend and the two-slot output stage.
module bml_back (
  input  logic               clk,
  input  logic               rst_n,
  input  bml_pkg::bml_cfg_t  cfg,
  input  logic               q_valid,
  input  bml_pkg::bml_item_t q_item,
  output logic               pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [23:0]        out_tdata,
  output logic               out_tlast
);

  typedef struct packed {
    logic [23:0] center;
    logic        flat;
    logic        dark1;
    logic        two;
    logic        dark2;
    logic        last2;
  } bml_tail_t;

  localparam int C1W = bml_pkg::DX_W + 1;
  localparam int C2W = bml_pkg::DY_W + 1;

  logic       s1_valid_r, s2_valid_r, s3_valid_r;
  bml_tail_t  s1_tail_r, s2_tail_r, s3_tail_r;
  logic [6:0] s1_c1_r, s1_c2_r;
  logic       s1_pos_r, s2_pos_r;
  logic [8:0] s1_scl_r, s2_scl_r;
  logic [13:0] s2_prod_r;
  logic [8:0] s3_lum_r;

  logic       o_valid_r, o_last_r, o2_valid_r, o2_last_r;
  logic [23:0] o_color_r, o2_color_r;
  logic       advance;

  logic [7:0] hl, hr, hu, hd;
  logic signed [C1W-1:0] t1, a1;
  logic signed [C2W-1:0] t2, a2;
  logic [19:0] scl_full;
  logic [22:0] lum_full;
  logic [23:0] lit, res;
  logic [9:0]  ch_lit;
  logic [8:0]  ch_add;
  logic [7:0]  s_ch, l_ch;

  assign advance = !o_valid_r || (out_tready && !o2_valid_r);
  assign pop     = advance && q_valid;

  always_comb begin
    hl = cfg.options[bml_pkg::OPT_INVERT] ? ~q_item.h_l : q_item.h_l;
    hr = cfg.options[bml_pkg::OPT_INVERT] ? ~q_item.h_r : q_item.h_r;
    hu = cfg.options[bml_pkg::OPT_INVERT] ? ~q_item.h_u : q_item.h_u;
    hd = cfg.options[bml_pkg::OPT_INVERT] ? ~q_item.h_d : q_item.h_d;
    t1 = $signed(C1W'(hr)) - $signed(C1W'(hl)) - C1W'(q_item.dx);
    t2 = $signed(C2W'(hd)) - $signed(C2W'(hu)) - C2W'(q_item.dy);
    a1 = (t1 < 0) ? -t1 : t1;
    a2 = (t2 < 0) ? -t2 : t2;
    scl_full = 20'(q_item.depth) * 20'(bml_pkg::RECIP_100);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= q_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_tail_r <= '{center: q_item.center, flat: q_item.flat, dark1: q_item.dark1,
                     two: q_item.two, dark2: q_item.dark2, last2: q_item.last2};
      s1_pos_r  <= (a1 < C1W'(bml_pkg::SLOPE_MAX)) && (a2 < C2W'(bml_pkg::SLOPE_MAX));
      s1_c1_r   <= 7'(C1W'(bml_pkg::SLOPE_MAX) - a1);
      s1_c2_r   <= 7'(C2W'(bml_pkg::SLOPE_MAX) - a2);
      s1_scl_r  <= 9'(scl_full >> bml_pkg::SCALE_SHIFT);
      s2_tail_r <= s1_tail_r;
      s2_pos_r  <= s1_pos_r;
      s2_scl_r  <= s1_scl_r;
      s2_prod_r <= 14'(s1_c1_r) * 14'(s1_c2_r);
      s3_tail_r <= s2_tail_r;
      s3_lum_r  <= s2_pos_r ? 9'(lum_full >> bml_pkg::LIGHT_SHIFT) : 9'd0;
    end
  end

  assign lum_full = 23'(s2_prod_r) * 23'(s2_scl_r);

  always_comb begin
    lit = '0;
    res = '0;
    for (int c = 0; c < 3; c++) begin
      s_ch   = s3_tail_r.center[8*c +: 8];
      ch_lit = 10'(s_ch) + 10'(s3_lum_r);
      l_ch   = (ch_lit > 10'(bml_pkg::CH_CLAMP)) ? bml_pkg::CH_CLAMP : ch_lit[7:0];
      lit[8*c +: 8] = l_ch;
      ch_add = 9'(s_ch) + 9'(l_ch);
      case (cfg.options[4:3])
        bml_pkg::BLEND_ADD:  res[8*c +: 8] = ch_add[8] ? bml_pkg::CH_MAX : ch_add[7:0];
        bml_pkg::BLEND_MEAN: res[8*c +: 8] = (s_ch >> 1) + (l_ch >> 1);
        default:             res[8*c +: 8] = l_ch;
      endcase
    end
    if (s3_tail_r.flat) begin
      res = s3_tail_r.dark1 ? bml_pkg::WHITE : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r  <= 1'b0;
      o2_valid_r <= 1'b0;
    end else if (advance && s3_valid_r) begin
      o_valid_r  <= 1'b1;
      o2_valid_r <= s3_tail_r.two;
    end else if (out_tready && o_valid_r) begin
      o_valid_r  <= o2_valid_r;
      o2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s3_valid_r) begin
      o_color_r  <= res;
      o_last_r   <= 1'b0;
      o2_color_r <= s3_tail_r.dark2 ? bml_pkg::WHITE : '0;
      o2_last_r  <= s3_tail_r.last2;
    end else if (out_tready && o_valid_r && o2_valid_r) begin
      o_color_r <= o2_color_r;
      o_last_r  <= o2_last_r;
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_tdata  = o_color_r;
  assign out_tlast  = o_last_r;

endmodule

// ===== rtl/bml_checker.sv =====
// Port-level checker for the bump map lighting block, with its bind.
`include "assert_macros.svh"

module bml_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  `BML_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `BML_ASSERT_NEXT(a_out_data_hold, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))
  `BML_ASSERT_NOW(a_last_dark, clk, rst_n, out_tvalid && out_tlast, out_tdata == 24'h0 || out_tdata == 24'hFFFFFF)
  `BML_ASSERT_RESET(a_rst_out_idle, clk, rst_n, !out_tvalid)
  `BML_ASSERT_RESET(a_rst_in_hold, clk, rst_n, !in_tready)

endmodule

bind bump_map_lighting bml_checker u_bml_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
